// File: rtl/m2ts_pkg.sv
// Shared types and constants for the M2TS-to-TS packet stripper.
// Depends on nothing; the chain, top level, checker and testbench import it.
package m2ts_pkg;

  // Sync byte value after reset
  localparam logic [7:0] SYNC_RESET = 8'h47;

  // Input item: data byte or end-of-stream flush tick
  typedef struct packed {
    logic       mode;
    logic [7:0] in_byte;
  } m2ts_in_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_first;
    logic       packet_last;
    logic       failed;
  } m2ts_out_t;

  // Stream phase
  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_VERIFY,
    PH_LOCKED,
    PH_FLUSH,
    PH_FAILED
  } m2ts_phase_t;

  // Per-cycle command to the cell row
  typedef struct packed {
    logic shift;  // every cell takes its lower neighbor, head byte leaves
    logic load;   // the addressed cell takes the new byte
  } m2ts_chain_ctl_t;

endpackage

// File: rtl/m2ts_cell.sv
// One byte cell of the delay row: hold, take the lower neighbor, or load.
// Standalone; used by m2ts_chain.
module m2ts_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic       load,
  input  logic [7:0] d_prev,
  input  logic [7:0] d_new,
  output logic [7:0] q
);

  logic [7:0] q_r;
  logic [7:0] q_nxt;

  // Select the next byte: a load wins over a shift
  always_comb begin
    q_nxt = q_r;
    if (load) begin
      q_nxt = d_new;
    end else if (shift) begin
      q_nxt = d_prev;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// File: rtl/m2ts_chain.sv
// Row of byte cells forming the packet delay line; the oldest byte sits
// in the top cell. Depends on m2ts_pkg and m2ts_cell.
module m2ts_chain #(
  parameter int DEPTH = 192
) (
  input  logic                         clk,
  input  m2ts_pkg::m2ts_chain_ctl_t    ctl,
  input  logic [$clog2(DEPTH)-1:0]     wr_idx,
  input  logic [7:0]                   new_byte,
  output logic [7:0]                   head_byte
);

  import m2ts_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic [7:0] q [DEPTH];

  // Build the row; cell 0 is fed the new byte on a shift
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic       load_k;
    logic [7:0] prev_k;

    assign load_k = ctl.load && (wr_idx == IW'(k));

    if (k == 0) begin : g_first
      assign prev_k = new_byte;
    end else begin : g_rest
      assign prev_k = q[k-1];
    end

    m2ts_cell u_cell (
      .clk    (clk),
      .shift  (ctl.shift),
      .load   (load_k),
      .d_prev (prev_k),
      .d_new  (new_byte),
      .q      (q[k])
    );
  end

  // Oldest held byte
  assign head_byte = q[DEPTH-1];

endmodule

// File: rtl/m2ts_to_ts_packet_stripper.sv
// Top level of the M2TS-to-TS packet stripper: control, counters, output stage.
// Depends on m2ts_pkg and m2ts_chain.
//
// Usage:
//   in_*  : one transaction per stream byte (mode 0) or flush tick (mode 1).
//   out_* : 188-byte transport packets with first/last flags, or one result
//           with failed set when the stream is not in 192-byte packet format.
//   cfg_* : writes the sync byte value (0x47 after reset); write only while idle.
// The first sync byte must follow at least PREFIX_BYTES bytes and must repeat
// PACKET_BYTES bytes later; after that the block is locked and every byte runs
// through a PACKET_BYTES-cell delay row, prefix bytes being dropped at its end.
// Results: a data byte's result is registered in the output register, or in the
// skid entry while that one is full; a flush result follows the prefix drop.
// Throughput: one data byte per cycle while in_ready is high, set by the cell row
// shifting once per byte. A flush tick in the locked phase holds in_ready low
// while the row drops held prefix bytes one per cycle.
// Reset: synchronous; the block searches for sync again and the delay row needs
// no clearing. After a failure every transaction is taken and yields nothing.
// Stall: a two-entry output stage keeps taking input while one result waits;
// outside a flush, in_ready drops only once both entries hold results.
module m2ts_to_ts_packet_stripper #(
  parameter int PACKET_BYTES = 192,
  parameter int PREFIX_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  m2ts_pkg::m2ts_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output m2ts_pkg::m2ts_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  import m2ts_pkg::*;

  localparam int TS_BYTES = PACKET_BYTES - PREFIX_BYTES;
  localparam int IW = $clog2(PACKET_BYTES);
  localparam int PW = $clog2(PACKET_BYTES + 1);
  localparam int LW = $clog2(PREFIX_BYTES + 1);

  m2ts_phase_t     phase_r, phase_nxt;
  logic [LW-1:0]   lead_r, lead_nxt;
  logic [IW-1:0]   pos_r, pos_nxt;
  logic [PW-1:0]   pend_r, pend_nxt;
  logic [7:0]      sync_r;

  logic            out_v_r, out_v_nxt;
  m2ts_out_t       out_d_r, out_d_nxt;
  logic            skid_v_r, skid_v_nxt;
  m2ts_out_t       skid_d_r, skid_d_nxt;

  logic            in_fire;
  logic            out_fire;
  logic            full;
  logic            is_sync;
  logic            lead_short;
  logic            prefix_head;
  logic            rest_held;
  logic [IW-1:0]   pos_inc;
  logic [IW-1:0]   wr_idx;
  logic [7:0]      head_byte;
  m2ts_chain_ctl_t ctl;
  logic            res_v;
  m2ts_out_t       res;
  m2ts_out_t       pop_res;
  m2ts_out_t       fail_res;

  // Handshakes
  assign in_ready  = !skid_v_r && (phase_r != PH_FLUSH);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_v_r && out_ready;
  assign cfg_ready = 1'b1;

  // Status of the delay row
  assign full        = (pend_r == PW'(PACKET_BYTES));
  assign is_sync     = (in_data.in_byte == sync_r);
  assign lead_short  = (lead_r < LW'(PREFIX_BYTES));
  assign prefix_head = (pend_r != '0) && (pos_r >= IW'(TS_BYTES));
  assign rest_held   = (pend_r != '0) &&
                       (({1'b0, pend_r} + (PW+1)'(pos_r)) >= (PW+1)'(TS_BYTES));
  assign pos_inc     = (pos_r == IW'(PACKET_BYTES - 1)) ? '0 : pos_r + IW'(1);
  assign wr_idx      = IW'(PACKET_BYTES - 1) - pend_r[IW-1:0];

  // Result for the head byte leaving the row, and the failure result
  always_comb begin
    pop_res              = '0;
    pop_res.out_byte     = head_byte;
    pop_res.packet_first = (pos_r == '0);
    pop_res.packet_last  = (pos_r == IW'(TS_BYTES - 1));
    fail_res             = '0;
    fail_res.failed      = 1'b1;
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_SEARCH: begin
        if (in_fire) begin
          if (in_data.mode) begin
            phase_nxt = PH_FAILED;
          end else if (is_sync) begin
            phase_nxt = lead_short ? PH_FAILED : PH_VERIFY;
          end
        end
      end
      PH_VERIFY: begin
        if (in_fire) begin
          if (in_data.mode) begin
            phase_nxt = PH_FAILED;
          end else if (full) begin
            phase_nxt = is_sync ? PH_LOCKED : PH_FAILED;
          end
        end
      end
      PH_LOCKED: begin
        if (in_fire && in_data.mode) begin
          phase_nxt = PH_FLUSH;
        end
      end
      PH_FLUSH: begin
        if (!prefix_head) begin
          phase_nxt = PH_LOCKED;
        end
      end
      PH_FAILED: begin
        phase_nxt = PH_FAILED;
      end
      default: begin
        phase_nxt = PH_FAILED;
      end
    endcase
  end

  // Row commands, counters and results per phase
  always_comb begin
    ctl      = '0;
    res_v    = 1'b0;
    res      = '0;
    lead_nxt = lead_r;
    pos_nxt  = pos_r;
    pend_nxt = pend_r;
    case (phase_r)
      PH_SEARCH: begin
        if (in_fire) begin
          if (in_data.mode) begin
            res_v = 1'b1;
            res   = fail_res;
          end else if (is_sync) begin
            if (lead_short) begin
              res_v = 1'b1;
              res   = fail_res;
            end else begin
              ctl.load = 1'b1;
              pos_nxt  = '0;
              pend_nxt = PW'(1);
            end
          end else if (lead_short) begin
            lead_nxt = lead_r + LW'(1);
          end
        end
      end
      PH_VERIFY: begin
        if (in_fire) begin
          if (in_data.mode || (full && !is_sync)) begin
            res_v = 1'b1;
            res   = fail_res;
          end else if (!full) begin
            ctl.load = 1'b1;
            pend_nxt = pend_r + PW'(1);
          end else begin
            ctl.shift = 1'b1;
            res_v     = (pos_r < IW'(TS_BYTES));
            res       = pop_res;
            pos_nxt   = pos_inc;
          end
        end
      end
      PH_LOCKED: begin
        if (in_fire && !in_data.mode) begin
          if (full) begin
            ctl.shift = 1'b1;
            res_v     = (pos_r < IW'(TS_BYTES));
            res       = pop_res;
            pos_nxt   = pos_inc;
          end else begin
            ctl.load = 1'b1;
            pend_nxt = pend_r + PW'(1);
          end
        end
      end
      PH_FLUSH: begin
        // Drop held prefix bytes, then release one byte of a complete packet
        if (prefix_head) begin
          ctl.shift = 1'b1;
          pos_nxt   = pos_inc;
          pend_nxt  = pend_r - PW'(1);
        end else if (rest_held) begin
          ctl.shift = 1'b1;
          res_v     = 1'b1;
          res       = pop_res;
          pos_nxt   = pos_inc;
          pend_nxt  = pend_r - PW'(1);
        end
      end
      PH_FAILED: begin
        res_v = 1'b0;
      end
      default: begin
        res_v = 1'b0;
      end
    endcase
  end

  // Delay row
  m2ts_chain #(
    .DEPTH (PACKET_BYTES)
  ) u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .wr_idx    (wr_idx),
    .new_byte  (in_data.in_byte),
    .head_byte (head_byte)
  );

  // Two-entry output stage: output register plus skid entry
  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (out_fire) begin
      out_v_nxt = 1'b0;
    end
    if (skid_v_r && !out_v_nxt) begin
      out_v_nxt  = 1'b1;
      out_d_nxt  = skid_d_r;
      skid_v_nxt = 1'b0;
    end
    if (res_v) begin
      if (!out_v_nxt) begin
        out_v_nxt = 1'b1;
        out_d_nxt = res;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = res;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      lead_r   <= '0;
      pos_r    <= '0;
      pend_r   <= '0;
      sync_r   <= SYNC_RESET;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      lead_r   <= lead_nxt;
      pos_r    <= pos_nxt;
      pend_r   <= pend_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
      if (cfg_valid && cfg_ready) begin
        sync_r <= cfg_data;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

// File: rtl/m2ts_checker.sv
// Port-level checks for the M2TS-to-TS packet stripper, bound to the top level.
// Depends on m2ts_pkg and m2ts_to_ts_packet_stripper.
module m2ts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input m2ts_pkg::m2ts_out_t out_data
);

  import m2ts_pkg::*;

  // No result is valid right after a failure transaction is delivered
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.failed |=> !out_valid)
    else $error("result delivered after failure");

  // Failure transaction carries no byte and no packet flags
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.failed |->
      out_data.out_byte == 8'h00 && !out_data.packet_first && !out_data.packet_last)
    else $error("failure result carries payload");

  // A byte never opens and closes a packet at once
  a_first_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.packet_first && out_data.packet_last))
    else $error("packet_first and packet_last together");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind m2ts_to_ts_packet_stripper m2ts_checker u_checker (.*);

// File: tb/sv/m2ts_to_ts_packet_stripper_test.sv
// Self-checking testbench for the M2TS-to-TS packet stripper: drives byte and flush
// transactions, predicts the stripped 188-byte packet stream and checks every result.
// Depends on m2ts_pkg and the m2ts_to_ts_packet_stripper RTL.
`timescale 1ns / 1ps

module m2ts_to_ts_packet_stripper_test;
  import m2ts_pkg::*;

  localparam int PACKET_BYTES  = 192;
  localparam int PREFIX_BYTES  = 4;
  localparam int TS_BYTES      = PACKET_BYTES - PREFIX_BYTES;
  localparam int SETTLE_CYCLES = 2 * PREFIX_BYTES + 8;
  localparam int PHASE_ITEMS   = 100;
  localparam int RUN_LIMIT     = 400000;
  localparam int MAX_REPORTS   = 10;

  localparam logic MODE_DATA  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef enum {
    OPEN_LOCK,
    OPEN_FEW_LEAD,
    OPEN_NO_SECOND,
    OPEN_EARLY_FLUSH
  } opening_t;

  // Predicts the stripped stream and holds the results still to come
  class strip_scoreboard;
    m2ts_out_t   expected_q[$];
    m2ts_phase_t stream_phase;
    logic [7:0]  sync_byte;
    logic [7:0]  row [PACKET_BYTES];
    int          lead_cnt;
    int          head_pos;
    int          held_cnt;
    int          failures;

    function new();
      sync_byte    = SYNC_RESET;
      stream_phase = PH_SEARCH;
      lead_cnt     = 0;
      head_pos     = 0;
      held_cnt     = 0;
      failures     = 0;
    endfunction

    function void set_sync(logic [7:0] value);
      sync_byte = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit enter_failed(output m2ts_out_t r);
      stream_phase = PH_FAILED;
      r = '0;
      r.failed = 1'b1;
      return 1'b1;
    endfunction

    // Take the oldest held byte out of the row; only transport bytes are emitted
    function bit take_head(output m2ts_out_t r);
      int slot;
      slot = head_pos % PACKET_BYTES;
      r = '0;
      held_cnt--;
      head_pos = (slot + 1) % PACKET_BYTES;
      if (slot >= TS_BYTES) return 1'b0;
      r.out_byte     = row[slot];
      r.packet_first = (slot == 0);
      r.packet_last  = (slot == TS_BYTES - 1);
      return 1'b1;
    endfunction

    function void note_input(m2ts_in_t item);
      m2ts_out_t res;
      bit        emit;
      emit = 1'b0;
      res  = '0;
      if (stream_phase == PH_FAILED) return;
      if (item.mode == MODE_FLUSH) begin
        if (stream_phase == PH_LOCKED) begin
          // drop held prefix bytes, then release one byte if its packet is complete
          while (held_cnt > 0 && head_pos >= TS_BYTES) void'(take_head(res));
          if (held_cnt > 0 && held_cnt >= TS_BYTES - head_pos) emit = take_head(res);
        end else begin
          emit = enter_failed(res);
        end
      end else if (stream_phase == PH_SEARCH) begin
        if (item.in_byte == sync_byte) begin
          if (lead_cnt < PREFIX_BYTES) begin
            emit = enter_failed(res);
          end else begin
            stream_phase = PH_VERIFY;
            row[0]   = item.in_byte;
            head_pos = 0;
            held_cnt = 1;
          end
        end else if (lead_cnt < PREFIX_BYTES) begin
          lead_cnt++;
        end
      end else if (stream_phase == PH_VERIFY && held_cnt < PACKET_BYTES) begin
        row[held_cnt] = item.in_byte;
        held_cnt++;
      end else if (stream_phase == PH_VERIFY && item.in_byte != sync_byte) begin
        emit = enter_failed(res);
      end else begin
        // a matching second sync locks and is then handled as any locked byte
        stream_phase = PH_LOCKED;
        if (held_cnt >= PACKET_BYTES) emit = take_head(res);
        row[(head_pos + held_cnt) % PACKET_BYTES] = item.in_byte;
        held_cnt++;
      end
      if (emit) expected_q.push_back(res);
    endfunction

    function void check_result(m2ts_out_t got);
      m2ts_out_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: byte %02h first %0b last %0b failed %0b",
                   got.out_byte, got.packet_first, got.packet_last, got.failed);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte || got.packet_first !== want.packet_first ||
          got.packet_last !== want.packet_last || got.failed !== want.failed) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display({"mismatch: expected byte %02h first %0b last %0b failed %0b, ",
                    "got byte %02h first %0b last %0b failed %0b"},
                   want.out_byte, want.packet_first, want.packet_last, want.failed,
                   got.out_byte, got.packet_first, got.packet_last, got.failed);
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  m2ts_in_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  m2ts_out_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  strip_scoreboard sb;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int items_sent     = 0;
  int stream_pos     = 0;
  int cycle_count    = 0;
  logic [7:0] lock_sync;

  m2ts_to_ts_packet_stripper #(
    .PACKET_BYTES(PACKET_BYTES),
    .PREFIX_BYTES(PREFIX_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Observe every transaction on the three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_sync(cfg_data);
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function automatic logic [7:0] other_than(input logic [7:0] value);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == value) b = b + 8'd1;
    return b;
  endfunction

  // Hold one transaction on the input channel until it is accepted
  task automatic send_item(input m2ts_in_t item);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_data(input logic [7:0] b);
    m2ts_in_t item;
    item.mode    = MODE_DATA;
    item.in_byte = b;
    send_item(item);
  endtask

  task automatic send_flush();
    m2ts_in_t item;
    item.mode    = MODE_FLUSH;
    item.in_byte = 8'($urandom_range(0, 255));
    send_item(item);
  endtask

  // Mostly well-formed packets: sync at each packet start, random elsewhere
  task automatic send_stream(input int count);
    logic [7:0] b;
    repeat (count) begin
      if (stream_pos == 0 && $urandom_range(0, 15) != 0) b = lock_sync;
      else b = 8'($urandom_range(0, 255));
      send_data(b);
      stream_pos = (stream_pos + 1) % PACKET_BYTES;
    end
  endtask

  // Stop sending until every predicted result has come out, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    opening_t opening;
    int       pick;
    int       start;
    int       left;
    int       n;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pick the sync value for the lock: reset value, extremes or random
    case ($urandom_range(0, 3))
      0:       lock_sync = SYNC_RESET;
      1:       lock_sync = 8'h00;
      2:       lock_sync = 8'hFF;
      default: lock_sync = 8'($urandom_range(0, 255));
    endcase
    if (lock_sync != SYNC_RESET) write_sync(lock_sync);

    // A failure is final until reset, so most runs lock and a few open with a failure
    pick = $urandom_range(0, 15);
    if (pick == 0) opening = OPEN_FEW_LEAD;
    else if (pick == 1) opening = OPEN_NO_SECOND;
    else if (pick == 2) opening = OPEN_EARLY_FLUSH;
    else opening = OPEN_LOCK;

    case (opening)
      OPEN_FEW_LEAD: begin
        repeat ($urandom_range(0, PREFIX_BYTES - 1)) send_data(other_than(lock_sync));
        send_data(lock_sync);
      end
      OPEN_EARLY_FLUSH: begin
        if ($urandom_range(0, 1) == 0) begin
          repeat ($urandom_range(0, 6)) send_data(other_than(lock_sync));
        end else begin
          repeat (PREFIX_BYTES) send_data(other_than(lock_sync));
          send_data(lock_sync);
          repeat ($urandom_range(0, PACKET_BYTES - 1)) send_data(8'($urandom_range(0, 255)));
        end
        send_flush();
      end
      default: begin
        repeat ($urandom_range(PREFIX_BYTES, PREFIX_BYTES + 3))
          send_data(other_than(lock_sync));
        send_data(lock_sync);
        send_data(8'h00);
        send_data(8'hFF);
        repeat (PACKET_BYTES - 3) send_data(8'($urandom_range(0, 255)));
        if (opening == OPEN_NO_SECOND) send_data(other_than(lock_sync));
        else send_data(lock_sync);
      end
    endcase
    stream_pos = 1;

    // Random traffic in four idling phases, with a register write before each phase
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: begin
          src_idle_pct = 0;  sink_stall_pct = 0;  write_sync(8'h00);
        end
        1: begin
          src_idle_pct = 47; sink_stall_pct = 0;  write_sync(8'hFF);
        end
        2: begin
          src_idle_pct = 0;  sink_stall_pct = 47; write_sync(8'($urandom_range(0, 255)));
        end
        default: begin
          src_idle_pct = 7;  sink_stall_pct = 7;  write_sync(lock_sync);
        end
      endcase
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        // Keep each burst within what is left of the phase
        left = PHASE_ITEMS - (items_sent - start);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          n = $urandom_range(1, 120);
          send_stream((n < left) ? n : left);
        end else if (pick < 80) begin
          n = $urandom_range(1, 6);
          repeat ((n < left) ? n : left) send_flush();
        end else if (pick < 88) begin
          repeat ((PACKET_BYTES + 2 < left) ? PACKET_BYTES + 2 : left) send_flush();
        end else if (pick < 94) begin
          send_stream((PACKET_BYTES < left) ? PACKET_BYTES : left);
        end else begin
          drain_results();
        end
      end
    end

    drain_results();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/m2ts_pkg.sv
rtl/m2ts_cell.sv
rtl/m2ts_chain.sv
rtl/m2ts_to_ts_packet_stripper.sv
rtl/m2ts_checker.sv
tb/sv/m2ts_to_ts_packet_stripper_test.sv
